@@ rtl/core/b64e_pkg.sv @@
// ============================================================================
// b64e_pkg
// Shared widths, character codes, the group type and the sextet-to-character
// mapping of the streaming base64 encoder.
// ============================================================================
package b64e_pkg;

	localparam int BYTE_W = 8;
	localparam int CHAR_W = 7;

	// Character codes used by the encoder.
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'd65;  // 'A'
	localparam logic [CHAR_W-1:0] CH_LOWER_OFS = 7'd71;  // 'a' minus 26
	localparam logic [CHAR_W-1:0] CH_DIGIT_OFS = 7'd4;   // 52 minus '0'
	localparam logic [CHAR_W-1:0] CH_PLUS = 7'd43;  // '+'
	localparam logic [CHAR_W-1:0] CH_SLASH = 7'd47;  // '/'
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;  // '-'
	localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 7'd95;  // '_'
	localparam logic [CHAR_W-1:0] PAD_STD = 7'd61;  // '='
	localparam logic [CHAR_W-1:0] PAD_URL = 7'd46;  // '.'

	localparam logic [5:0] SEXTET_UPPER_END = 6'd26;
	localparam logic [5:0] SEXTET_LOWER_END = 6'd52;
	localparam logic [5:0] SEXTET_DIGIT_END = 6'd62;
	localparam logic [5:0] SEXTET_MARK_62 = 6'd62;

	// One finished group: three bytes (missing ones zero), how many of them
	// are real (1 to 3), and whether it closes the message.
	typedef struct packed {
		logic [3*BYTE_W-1:0] bits;
		logic [1:0]          nbytes;
		logic                eom;
	} b64e_group_t;

	function automatic logic [CHAR_W-1:0] sextet_to_char(input logic [5:0] v,
		input logic url);
		logic [CHAR_W-1:0] c;
		logic [CHAR_W-1:0] v_ext;
		v_ext = {1'b0, v};
		if (v < SEXTET_UPPER_END) begin
			c = CH_UPPER_A + v_ext;
		end else if (v < SEXTET_LOWER_END) begin
			c = CH_LOWER_OFS + v_ext;
		end else if (v < SEXTET_DIGIT_END) begin
			c = v_ext - CH_DIGIT_OFS;
		end else if (v == SEXTET_MARK_62) begin
			c = url ? CH_MINUS : CH_PLUS;
		end else begin
			c = url ? CH_UNDERSCORE : CH_SLASH;
		end
		return c;
	endfunction

endpackage

@@ rtl/core/b64e_byte_if.sv @@
// ============================================================================
// b64e_byte_if
// Byte stream channel: valid/ready handshake with one message byte per beat.
// ============================================================================
interface b64e_byte_if import b64e_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

@@ rtl/core/b64e_char_if.sv @@
// ============================================================================
// b64e_char_if
// Character stream channel: valid/ready handshake with one ASCII character
// per beat.
// ============================================================================
interface b64e_char_if import b64e_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	logic              last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface

@@ rtl/core/base64_stream_encoder_core.sv @@
// ============================================================================
// base64_stream_encoder_core
// Streaming base64 encoder: message bytes in, ASCII characters out.
// ============================================================================
// The block takes a message one byte per beat on "bytes", the final byte
// flagged by end_of_message, and sends base64 characters one per beat on
// "chars". Every group of three bytes gives four characters; a message that
// ends on a partial group is zero-filled and padded to four characters with
// '=' (standard alphabet, +/) or '.' (URL alphabet, -_), chosen by the one
// configuration bit written through cfg_write_en/cfg_write_data, which
// should only change while the block is idle. The final character of every
// message carries last_char. Rate: a byte is taken in any cycle in which the
// group register ahead of the character stage is free, so bytes that do not
// finish a group pass at one per cycle, while every finished group occupies
// the character stage for its four characters, one per output beat. A steady
// stream therefore gives four characters per three bytes, set by the single
// output beat per cycle; a message of one byte still gives four characters.
// The first character of a group follows the byte that closes it through the
// group register, the character stage's group buffer and the output register.

module base64_stream_encoder_core import b64e_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         cfg_write_en,
	input logic         cfg_write_data,
	b64e_byte_if.sink   bytes,
	b64e_char_if.source chars
);

	// Alphabet selection: 0 standard with '=' padding, 1 URL-safe with '.'.
	logic url_q;

	// Finished group handed from the byte packer to the character stage.
	logic        grp_valid;
	logic        grp_ready;
	b64e_group_t grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_q <= 1'b0;
		end else if (cfg_write_en) begin
			url_q <= cfg_write_data;
		end
	end

	// The packer keeps the group position and the held bytes, and registers
	// each group as soon as it is complete or the message ends.
	b64e_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (bytes),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready),
		.grp       (grp)
	);

	// The character stage buffers one group, so the packer can already hold
	// the next one while the current group is still being sent.
	b64e_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.url       (url_q),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready),
		.grp       (grp),
		.chars     (chars)
	);

endmodule

@@ rtl/core/b64e_pack.sv @@
// ============================================================================
// b64e_pack
// Gathers incoming bytes into groups of three and registers each finished
// (or message-closing) group for the character stage.
// ============================================================================
module b64e_pack import b64e_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	b64e_byte_if.sink   bytes,
	output logic        grp_valid,
	input  logic        grp_ready,
	output b64e_group_t grp
);

	logic [1:0]        pos_q;
	logic [15:0]       pend_q;
	logic              grp_valid_s1;
	b64e_group_t       grp_s1;

	logic              accept;
	logic [1:0]        pos_eff;
	logic [1:0]        nbytes;
	logic              flush;
	logic [BYTE_W-1:0] b0;
	logic [BYTE_W-1:0] b1;
	logic [BYTE_W-1:0] b2;

	assign bytes.ready = !grp_valid_s1 || grp_ready;
	assign accept = bytes.valid && bytes.ready;

	// Position three never occurs; it is folded onto two.
	assign pos_eff = (pos_q == 2'd3) ? 2'd2 : pos_q;
	assign nbytes = pos_eff + 2'd1;
	assign flush = (nbytes == 2'd3) || bytes.end_of_message;

	always_comb begin
		b0 = (pos_eff == 2'd0) ? bytes.data_byte : pend_q[15:8];
		b1 = '0;
		b2 = '0;
		if (pos_eff == 2'd1) begin
			b1 = bytes.data_byte;
		end else if (pos_eff == 2'd2) begin
			b1 = pend_q[7:0];
			b2 = bytes.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pend_q <= '0;
			grp_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (flush) begin
					pos_q <= '0;
					pend_q <= '0;
				end else begin
					pos_q <= nbytes;
					pend_q <= (pos_eff == 2'd0) ? {bytes.data_byte, 8'h00}
						: {pend_q[15:8], bytes.data_byte};
				end
			end
			if (accept && flush) begin
				grp_valid_s1 <= 1'b1;
			end else if (grp_ready) begin
				grp_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && flush) begin
			grp_s1.bits <= {b0, b1, b2};
			grp_s1.nbytes <= nbytes;
			grp_s1.eom <= bytes.end_of_message;
		end
	end

	assign grp_valid = grp_valid_s1;
	assign grp = grp_s1;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd3)
		else $error("group position reached three");

	a_eom_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && bytes.end_of_message |=> pos_q == 2'd0 && pend_q == 16'h0000)
		else $error("group state not cleared after end of message");

	a_group_holds: assert property (@(posedge clk) disable iff (!arst_n)
		grp_valid_s1 && !grp_ready |=> grp_valid_s1 && $stable(grp_s1))
		else $error("pending group lost or changed while stalled");

endmodule

@@ rtl/core/b64e_emit.sv @@
// ============================================================================
// b64e_emit
// Holds one group and sends its four characters, one per beat, through a
// registered output.
// ============================================================================
module b64e_emit import b64e_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        url,
	input  logic        grp_valid,
	output logic        grp_ready,
	input  b64e_group_t grp,
	b64e_char_if.source chars
);

	logic              buf_valid_q;
	b64e_group_t       buf_q;
	logic [1:0]        cnt_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;

	logic              adv;
	logic              done;
	logic [5:0]        sextet;
	logic              is_data;
	logic [CHAR_W-1:0] char_d;
	logic              last_d;

	assign adv = buf_valid_q && (!out_valid_q || chars.ready);
	assign done = adv && (cnt_q == 2'd3);
	assign grp_ready = !buf_valid_q || done;

	always_comb begin
		case (cnt_q)
			2'd0: sextet = buf_q.bits[23:18];
			2'd1: sextet = buf_q.bits[17:12];
			2'd2: sextet = buf_q.bits[11:6];
			default: sextet = buf_q.bits[5:0];
		endcase
	end

	// A group of n real bytes yields n+1 data characters, the rest is padding.
	assign is_data = cnt_q <= buf_q.nbytes;
	assign char_d = is_data ? sextet_to_char(sextet, url) : (url ? PAD_URL : PAD_STD);
	assign last_d = buf_q.eom && (cnt_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (grp_ready) begin
				buf_valid_q <= grp_valid;
			end
			// The count wraps to zero on the fourth character, ready for the next group.
			if (adv) begin
				cnt_q <= cnt_q + 2'd1;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (chars.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grp_valid && grp_ready) begin
			buf_q <= grp;
		end
		if (adv) begin
			out_char_q <= char_d;
			out_last_q <= last_d;
		end
	end

	assign chars.valid = out_valid_q;
	assign chars.out_char = out_char_q;
	assign chars.last_char = out_last_q;

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!buf_valid_q |-> cnt_q == 2'd0)
		else $error("character count not at start while no group is held");

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("output register empty after a character was produced");

	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		done && buf_q.eom |=> out_valid_q && out_last_q)
		else $error("closing character of a message not marked");

endmodule

@@ tb/base64_stream_encoder_core_checker.sv @@
// ============================================================================
// base64_stream_encoder_core_checker
// Watches the byte and character channels of the base64 encoder, keeps its
// own copy of the group state and the alphabet bit, and compares every
// character beat against the characters that the accepted bytes call for.
// ============================================================================
module base64_stream_encoder_core_checker import b64e_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic              cfg_write_data,
	input  logic              byte_valid,
	input  logic              byte_ready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              end_of_message,
	input  logic              char_valid,
	input  logic              char_ready,
	input  logic [CHAR_W-1:0] out_char,
	input  logic              last_char,
	output int                mismatches,
	output int                chars_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ORD_UPPER_A = 65;
	localparam int ORD_LOWER_A = 97;
	localparam int ORD_DIGIT_0 = 48;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} b64_char_t;

	b64_char_t         chars_due[$];
	logic              url_mode;
	logic [1:0]        held_count;
	logic [15:0]       held_bytes;
	int                fails;

	function automatic logic [CHAR_W-1:0] sextet_glyph(input logic [5:0] s, input logic url);
		int v;
		v = int'(s);
		if (v < 26) begin
			return CHAR_W'(ORD_UPPER_A + v);
		end else if (v < 52) begin
			return CHAR_W'(ORD_LOWER_A + v - 26);
		end else if (v < 62) begin
			return CHAR_W'(ORD_DIGIT_0 + v - 52);
		end else if (v == 62) begin
			return url ? CH_MINUS : CH_PLUS;
		end
		return url ? CH_UNDERSCORE : CH_SLASH;
	endfunction

	// Adds one message byte to the held group and queues the four characters
	// of a group once it is full or the message ends.
	task automatic encode_byte(input logic [BYTE_W-1:0] b, input logic eom);
		logic [1:0]  pos;
		int          n_real;
		int          i;
		logic [23:0] grp;
		b64_char_t   c;
		pos = (held_count > 2'd2) ? 2'd2 : held_count;
		if (pos == 2'd0) begin
			held_bytes = {b, 8'h00};
		end else if (pos == 2'd1) begin
			held_bytes[7:0] = b;
		end
		n_real = int'(pos) + 1;
		if (n_real < 3 && !eom) begin
			held_count = 2'(n_real);
			return;
		end
		grp = {held_bytes[15:8], (n_real >= 2) ? held_bytes[7:0] : 8'h00,
			(n_real == 3) ? b : 8'h00};
		for (i = 0; i < 4; i++) begin
			if (i <= n_real) begin
				c.code = sextet_glyph(grp[23 - 6 * i -: 6], url_mode);
			end else begin
				c.code = url_mode ? PAD_URL : PAD_STD;
			end
			c.last = eom && (i == 3);
			chars_due.push_back(c);
		end
		held_count = 2'd0;
		held_bytes = 16'h0000;
	endtask

	always @(posedge clk or negedge arst_n) begin
		b64_char_t want;
		if (!arst_n) begin
			chars_due.delete();
			url_mode = 1'b0;
			held_count = 2'd0;
			held_bytes = 16'h0000;
			fails = 0;
		end else begin
			if (char_valid && char_ready) begin
				if (chars_due.size() == 0) begin
					fails++;
					if (fails <= MAX_REPORTS) begin
						$display("%0t: character 0x%02h last %0b with nothing expected",
							$time, out_char, last_char);
					end
				end else begin
					want = chars_due.pop_front();
					if (out_char !== want.code || last_char !== want.last) begin
						fails++;
						if (fails <= MAX_REPORTS) begin
							$display("%0t: expected char 0x%02h last %0b, got 0x%02h last %0b",
								$time, want.code, want.last, out_char, last_char);
						end
					end
				end
			end
			if (cfg_write_en) begin
				url_mode = cfg_write_data;
			end
			if (byte_valid && byte_ready) begin
				encode_byte(data_byte, end_of_message);
			end
		end
		mismatches <= fails;
		chars_owed <= chars_due.size();
	end

endmodule

@@ tb/base64_stream_encoder_core_tb.sv @@
// ============================================================================
// base64_stream_encoder_core_tb
// Drives messages into the streaming base64 encoder under both alphabets and
// several idle patterns, and reports the verdict of the channel checker.
// ============================================================================
module base64_stream_encoder_core_tb import b64e_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles allowed for the whole run before it is called hung.
	localparam int CYCLE_LIMIT = 200000;
	// Length of the receiver hold-off that backs the encoder up into its input.
	localparam int LONG_HOLD = 120;
	// Cycles to let pass once nothing is owed, so that a group still in the
	// pipeline would show up before the alphabet changes or the run ends.
	localparam int SETTLE_CYCLES = 12;

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	logic cfg_write_data;

	b64e_byte_if bytes ();
	b64e_char_if chars ();

	int mismatches;
	int chars_owed;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_off_reqs;
	int cycle_count = 0;

	base64_stream_encoder_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.bytes          (bytes),
		.chars          (chars)
	);

	base64_stream_encoder_core_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.byte_valid     (bytes.valid),
		.byte_ready     (bytes.ready),
		.data_byte      (bytes.data_byte),
		.end_of_message (bytes.end_of_message),
		.char_valid     (chars.valid),
		.char_ready     (chars.ready),
		.out_char       (chars.out_char),
		.last_char      (chars.last_char),
		.mismatches     (mismatches),
		.chars_owed     (chars_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A hung encoder never drains its expected characters, so the run is
	// bounded by a plain cycle count.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[base64_stream_encoder_core] ERROR");
			$finish;
		end
	end

	// Character sink. Ready is drawn afresh every cycle from the current idle
	// percentage. When the stimulus asks for a hold-off, the sink keeps ready
	// low for a long stretch that it counts itself, so that the encoder fills
	// up and pushes back on the byte channel.
	initial begin : char_sink
		int seen_reqs;
		int hold_left;
		seen_reqs = 0;
		hold_left = 0;
		chars.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_reqs != seen_reqs) begin
				seen_reqs = hold_off_reqs;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				chars.ready <= 1'b0;
			end else begin
				chars.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offers one byte and returns at the edge where the beat is taken. Valid
	// is left high afterwards; the next call either idles or replaces the
	// payload, so valid never gets two assignments in one time step.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			bytes.valid <= 1'b0;
			@(posedge clk);
		end
		bytes.valid <= 1'b1;
		bytes.data_byte <= b;
		bytes.end_of_message <= eom;
		do @(posedge clk); while (!bytes.ready);
	endtask

	task automatic send_message(input int len);
		int k;
		for (k = 0; k < len; k++) begin
			send_byte(BYTE_W'($urandom_range(255)), k == len - 1);
		end
	endtask

	// Random messages, mostly short, until about the given byte count.
	task automatic send_random_messages(input int count);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(9, 1);
			send_message(len);
			sent += len;
		end
	endtask

	// Takes valid down and waits until every expected character has come,
	// then lets the settle period pass in case the encoder still holds a group.
	task automatic drain_chars();
		bytes.valid <= 1'b0;
		do @(posedge clk); while (chars_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The alphabet bit may only change while the encoder is idle.
	task automatic set_alphabet(input logic url);
		drain_chars();
		cfg_write_en <= 1'b1;
		cfg_write_data <= url;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	initial begin : stimulus
		bytes.valid <= 1'b0;
		bytes.data_byte <= '0;
		bytes.end_of_message <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_write_data <= 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_reqs = 0;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First phase: the sender idles lightly, the receiver heavily.
		send_idle_pct = 30;
		recv_idle_pct = 52;
		set_alphabet(1'b0);

		// A single byte message gives two characters and two pad marks.
		send_byte(8'h00, 1'b1);
		// Two bytes at the end give three characters and one pad mark.
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		// This group maps to sextets 62 and 63, the two alphabet-specific
		// characters, and ends exactly on a full group with no padding.
		send_byte(8'hFB, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hBF, 1'b1);
		// A full group followed by a lone final byte.
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6E, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFE, 1'b1);

		// The same special cases under the URL alphabet and its pad mark.
		set_alphabet(1'b1);
		send_byte(8'hFB, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hBF, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h10, 1'b0);
		send_byte(8'hC4, 1'b1);

		send_random_messages(20);

		// The receiver stops for a long stretch while a long message keeps
		// coming, so the encoder must stall its byte input.
		hold_off_reqs++;
		send_message(20);

		// The sender pauses until all characters are out before going on.
		drain_chars();

		// Second phase: the idle pattern is reversed.
		send_idle_pct = 52;
		recv_idle_pct = 30;
		set_alphabet(1'b0);
		send_random_messages(18);

		// Last phase: both sides run flat out.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random_messages(8);
		set_alphabet(1'b1);
		send_random_messages(8);

		drain_chars();
		if (mismatches == 0 && chars_owed == 0) begin
			$display("[base64_stream_encoder_core] OK");
		end else begin
			$display("[base64_stream_encoder_core] ERROR");
		end
		$finish;
	end

endmodule
